// ===== sv/json_string_unescape_utf8_unit_defines.svh =====
// Assertion macros shared by the JSON string unescape unit.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescape unit.
// Used by the front end, the job queue, the back end and the top level.
package jsu_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
        logic       string_done;
        logic [3:0] error_code;
    } result_t;

    // One classified input word; utf8 set means cp is expanded to 1 to 4 bytes.
    typedef struct packed {
        logic        utf8;
        logic [20:0] cp;
        logic        has_byte;
        logic        string_done;
        logic [3:0]  error_code;
    } job_t;

    localparam int QDepth = 4;
    localparam int QAddrW = $clog2(QDepth);

    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
    localparam logic [3:0] ERR_CONTROL      = 4'd2;
    localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd3;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd4;
    localparam logic [3:0] ERR_NO_LOW_ESC   = 4'd5;
    localparam logic [3:0] ERR_BAD_LOW      = 4'd6;
    localparam logic [3:0] ERR_LONE_LOW     = 4'd7;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd8;

endpackage

// ===== sv/jsu_front.sv =====
// Front end of the JSON string unescape unit: accepts input words, runs the
// string parser state machine and pushes one classified job per word.
// Depends on jsu_pkg.
module jsu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  jsu_pkg::item_t item,
    input  logic          q_full,
    output logic          push,
    output jsu_pkg::job_t  job
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX2,
        PH_HALT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [11:0] acc_reg, acc_next;
    logic [9:0]  first_reg, first_next;
    logic [4:0]  hex;
    logic [15:0] unit;
    logic [7:0]  c;

    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = '0;
        if (ch inside {[8'h30:8'h39]}) begin
            r = {1'b1, ch[3:0]};
        end
        else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, ch[3:0] + 4'd9};
        end
        return r;
    endfunction

    assign item_stall = q_full;
    assign push       = item_valid && !q_full;
    assign c          = item.in_byte;
    assign hex        = hex_decode(c);
    assign unit       = {acc_reg, hex[3:0]};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        first_next = first_reg;
        job        = '0;
        if (item.kind) begin
            phase_next = PH_IDLE;
            cnt_next   = '0;
            acc_next   = '0;
            first_next = '0;
            if (phase_reg != PH_HALT) begin
                job.error_code = ERR_UNTERMINATED;
            end
        end
        else begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (c != CH_QUOTE) begin
                        phase_next     = PH_HALT;
                        job.error_code = ERR_NO_QUOTE;
                    end
                    else begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (c == CH_QUOTE) begin
                        phase_next      = PH_HALT;
                        job.string_done = 1'b1;
                    end
                    else if (c < CH_SPACE) begin
                        phase_next     = PH_HALT;
                        job.error_code = ERR_CONTROL;
                    end
                    else if (c == CH_BSLASH) begin
                        phase_next = PH_ESC;
                    end
                    else begin
                        job.has_byte = 1'b1;
                        job.cp       = {13'd0, c};
                    end
                end
                PH_ESC:
                begin
                    phase_next   = PH_BODY;
                    job.has_byte = 1'b1;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: job.cp = {13'd0, c};
                        CH_B: job.cp = 21'h08;
                        CH_F: job.cp = 21'h0c;
                        CH_N: job.cp = 21'h0a;
                        CH_R: job.cp = 21'h0d;
                        CH_T: job.cp = 21'h09;
                        CH_U:
                        begin
                            phase_next   = PH_HEX1;
                            job.has_byte = 1'b0;
                            cnt_next     = '0;
                            acc_next     = '0;
                        end
                        default:
                        begin
                            phase_next     = PH_HALT;
                            job.has_byte   = 1'b0;
                            job.error_code = ERR_BAD_ESCAPE;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (!hex[4]) begin
                        phase_next     = PH_HALT;
                        job.error_code = ERR_BAD_HEX;
                    end
                    else begin
                        acc_next = unit[11:0];
                        if (cnt_reg != 2'd3) begin
                            cnt_next = cnt_reg + 2'd1;
                        end
                        else begin
                            cnt_next = '0;
                            if (phase_reg == PH_HEX1) begin
                                if (unit inside {[16'hd800:16'hdbff]}) begin
                                    first_next = unit[9:0];
                                    phase_next = PH_WANT_BS;
                                end
                                else if (unit inside {[16'hdc00:16'hdfff]}) begin
                                    phase_next     = PH_HALT;
                                    job.error_code = ERR_LONE_LOW;
                                end
                                else begin
                                    phase_next = PH_BODY;
                                    job.utf8   = 1'b1;
                                    job.cp     = {5'd0, unit};
                                end
                            end
                            else begin
                                if (!(unit inside {[16'hdc00:16'hdfff]})) begin
                                    phase_next     = PH_HALT;
                                    job.error_code = ERR_BAD_LOW;
                                end
                                else begin
                                    phase_next = PH_BODY;
                                    job.utf8   = 1'b1;
                                    job.cp     = 21'h10000 + {1'b0, first_reg, unit[9:0]};
                                end
                            end
                        end
                    end
                end
                PH_WANT_BS:
                begin
                    if (c != CH_BSLASH) begin
                        phase_next     = PH_HALT;
                        job.error_code = ERR_NO_LOW_ESC;
                    end
                    else begin
                        phase_next = PH_WANT_U;
                    end
                end
                PH_WANT_U:
                begin
                    if (c != CH_U) begin
                        phase_next     = PH_HALT;
                        job.error_code = ERR_NO_LOW_ESC;
                    end
                    else begin
                        phase_next = PH_HEX2;
                        cnt_next   = '0;
                        acc_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            first_reg <= '0;
        end
        else if (push) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== sv/jsu_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on jsu_pkg.
module jsu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::job_t  push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output jsu_pkg::job_t  head
);
    import jsu_pkg::*;

    job_t               slot_reg [QDepth];
    logic [QAddrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QAddrW:0]    count_reg, count_next;

    assign full       = (count_reg == QDepth[QAddrW:0]);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== sv/jsu_back.sv =====
// Back end of the JSON string unescape unit: expands each queued job into
// one to four result words, one per cycle while not stalled, through
// an output register. Depends on jsu_pkg.
module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  jsu_pkg::job_t    head,
    output logic            pop,
    output logic            result_valid,
    input  logic            result_stall,
    output jsu_pkg::result_t result
);
    import jsu_pkg::*;

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, word;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] len_m1;
    logic       load, word_last;
    logic [20:0] cp;

    assign cp = head.cp;

    always_comb
    begin
        if (cp <= 21'h7f) begin
            len_m1 = 2'd0;
        end
        else if (cp <= 21'h7ff) begin
            len_m1 = 2'd1;
        end
        else if (cp <= 21'hffff) begin
            len_m1 = 2'd2;
        end
        else begin
            len_m1 = 2'd3;
        end
    end

    assign load      = head_valid && (!out_valid_reg || !result_stall);
    assign word_last = !head.utf8 || (idx_reg == len_m1);
    assign pop       = load && word_last;

    always_comb
    begin
        word             = '0;
        word.last        = word_last;
        word.string_done = head.string_done;
        word.error_code  = head.error_code;
        if (head.utf8) begin
            word.has_byte = 1'b1;
            case ({len_m1, idx_reg})
                4'b00_00: word.out_byte = {1'b0, cp[6:0]};
                4'b01_00: word.out_byte = {3'b110, cp[10:6]};
                4'b01_01: word.out_byte = {2'b10, cp[5:0]};
                4'b10_00: word.out_byte = {4'b1110, cp[15:12]};
                4'b10_01: word.out_byte = {2'b10, cp[11:6]};
                4'b10_10: word.out_byte = {2'b10, cp[5:0]};
                4'b11_00: word.out_byte = {5'b11110, cp[20:18]};
                4'b11_01: word.out_byte = {2'b10, cp[17:12]};
                4'b11_10: word.out_byte = {2'b10, cp[11:6]};
                4'b11_11: word.out_byte = {2'b10, cp[5:0]};
                default:  word.out_byte = '0;
            endcase
        end
        else begin
            word.has_byte = head.has_byte;
            word.out_byte = head.has_byte ? cp[7:0] : 8'd0;
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (load) begin
            out_valid_next = 1'b1;
            idx_next       = word_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= word;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== sv/json_string_unescape_utf8_unit.sv =====
// JSON string unescape unit: takes a quoted JSON string one input word per
// cycle while item_stall is low and returns the unescaped text as UTF-8,
// one result word per byte, with errors and string completion flagged on
// the word's result. The front end accepts one input word every cycle while
// its four-entry job queue has room; each input word yields one result
// word, except a \u escape that completes a code point above 0x7f, which
// yields two to four. The back end sends one result word per cycle while
// result_stall is low, so the sustained rate is one input word per cycle
// when every word gives a single result, and the UTF-8 byte serializer sets
// it otherwise. A word's first result passes through the job queue and then
// the output register. Depends on jsu_pkg and the unit defines.
`include "json_string_unescape_utf8_unit_defines.svh"

module json_string_unescape_utf8_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  jsu_pkg::item_t    item,
    output logic             result_valid,
    input  logic             result_stall,
    output jsu_pkg::result_t  result
);
    import jsu_pkg::*;

    logic push, q_full, pop, head_valid;
    job_t push_job, head;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `JSU_ASSERT_SAME(a_error_no_byte,
        result_valid && (result.error_code != ERR_NONE),
        !result.has_byte && result.last && !result.string_done,
        "Error word carries a byte or is not last.")
    `JSU_ASSERT_SAME(a_done_is_last,
        result_valid && result.string_done,
        result.last && !result.has_byte,
        "Completion word is not a lone last word.")
    `JSU_ASSERT_NEXT(a_bytes_back_to_back,
        result_valid && !result.last && !result_stall,
        result_valid && result.has_byte,
        "UTF-8 sequence broken by a gap.")

endmodule

// ===== tb/json_string_unescape_utf8_unit_tb.sv =====
// Self-checking testbench for the JSON string unescape unit.
// Drives directed and random quoted strings, predicts every result word, and
// checks them in order. Depends on jsu_pkg and the json_string_unescape_utf8_unit RTL.
`timescale 1ns / 1ps

module json_string_unescape_utf8_unit_tb;

    import jsu_pkg::*;

    typedef enum logic [3:0] {
        P_IDLE, P_BODY, P_ESC, P_HEX1, P_WANT_BS, P_WANT_U, P_HEX2, P_HALT
    } scan_phase_e;

    typedef enum int {
        FLT_NONE, FLT_NO_QUOTE, FLT_CONTROL, FLT_BAD_ESCAPE, FLT_BAD_HEX,
        FLT_NO_BSLASH, FLT_NO_U, FLT_BAD_LOW, FLT_LONE_LOW, FLT_EARLY_END
    } fault_e;

    typedef struct {
        item_t   w;
        bit      typed;
        result_t want;
    } row_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic       KIND_DATA = 1'b0;
    localparam logic       KIND_END  = 1'b1;
    localparam int         RANDOM_WORDS = 280;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    scan_phase_e scan_phase = P_IDLE;
    logic [1:0]  digits_seen = '0;
    logic [15:0] high_unit = '0;
    logic [15:0] hex_acc = '0;

    result_t word_results[$];
    result_t expected_results[$];
    row_t    script[$];
    int      fails = 0;
    int      sent_words = 0;
    int      burst_left = 0;
    int      stall_mode = 0;
    int      mode_left = 0;
    int      stall_hold = 0;

    json_string_unescape_utf8_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int digit_value(logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b - "0");
        if (b >= "a" && b <= "f")
            return int'(b - "a") + 10;
        if (b >= "A" && b <= "F")
            return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic int escape_code(logic [7:0] b);
        case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: return int'(b);
            "b": return 'h08;
            "f": return 'h0c;
            "n": return 'h0a;
            "r": return 'h0d;
            "t": return 'h09;
            default: return -1;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 4'd10)
            return 8'("0" + n);
        return upper ? 8'("A" + n - 4'd10) : 8'("a" + n - 4'd10);
    endfunction

    task automatic add_result(logic [7:0] b, logic has, logic done, logic [3:0] err);
        result_t r;
        r.out_byte    = b;
        r.has_byte    = has;
        r.last        = 1'b0;
        r.string_done = done;
        r.error_code  = err;
        word_results.push_back(r);
    endtask

    task automatic halt_with(logic [3:0] err);
        scan_phase = P_HALT;
        add_result(8'h00, 1'b0, 1'b0, err);
    endtask

    task automatic add_utf8(int code);
        logic [20:0] c;
        c = code[20:0];
        if (code <= 'h7f)
            add_result(c[7:0], 1'b1, 1'b0, ERR_NONE);
        else if (code <= 'h7ff)
        begin
            add_result({3'b110, c[10:6]}, 1'b1, 1'b0, ERR_NONE);
            add_result({2'b10, c[5:0]}, 1'b1, 1'b0, ERR_NONE);
        end
        else if (code <= 'hffff)
        begin
            add_result({4'b1110, c[15:12]}, 1'b1, 1'b0, ERR_NONE);
            add_result({2'b10, c[11:6]}, 1'b1, 1'b0, ERR_NONE);
            add_result({2'b10, c[5:0]}, 1'b1, 1'b0, ERR_NONE);
        end
        else
        begin
            add_result({5'b11110, c[20:18]}, 1'b1, 1'b0, ERR_NONE);
            add_result({2'b10, c[17:12]}, 1'b1, 1'b0, ERR_NONE);
            add_result({2'b10, c[11:6]}, 1'b1, 1'b0, ERR_NONE);
            add_result({2'b10, c[5:0]}, 1'b1, 1'b0, ERR_NONE);
        end
    endtask

    task automatic unescape_word(item_t w);
        int d;
        int e;
        word_results.delete();
        if (w.kind == KIND_END)
        begin
            add_result(8'h00, 1'b0, 1'b0, (scan_phase == P_HALT) ? ERR_NONE : ERR_UNTERMINATED);
            scan_phase  = P_IDLE;
            digits_seen = '0;
            high_unit   = '0;
            hex_acc     = '0;
        end
        else
        begin
            case (scan_phase)
                P_IDLE:
                    if (w.in_byte != CH_QUOTE)
                        halt_with(ERR_NO_QUOTE);
                    else
                    begin
                        scan_phase = P_BODY;
                        add_result(8'h00, 1'b0, 1'b0, ERR_NONE);
                    end
                P_BODY:
                    if (w.in_byte == CH_QUOTE)
                    begin
                        scan_phase = P_HALT;
                        add_result(8'h00, 1'b0, 1'b1, ERR_NONE);
                    end
                    else if (w.in_byte < 8'h20)
                        halt_with(ERR_CONTROL);
                    else if (w.in_byte == CH_BSLASH)
                    begin
                        scan_phase = P_ESC;
                        add_result(8'h00, 1'b0, 1'b0, ERR_NONE);
                    end
                    else
                        add_result(w.in_byte, 1'b1, 1'b0, ERR_NONE);
                P_ESC:
                begin
                    e = escape_code(w.in_byte);
                    if (w.in_byte == CH_U)
                    begin
                        scan_phase  = P_HEX1;
                        digits_seen = '0;
                        hex_acc     = '0;
                        add_result(8'h00, 1'b0, 1'b0, ERR_NONE);
                    end
                    else if (e < 0)
                        halt_with(ERR_BAD_ESCAPE);
                    else
                    begin
                        scan_phase = P_BODY;
                        add_result(e[7:0], 1'b1, 1'b0, ERR_NONE);
                    end
                end
                P_HEX1, P_HEX2:
                begin
                    d = digit_value(w.in_byte);
                    if (d < 0)
                        halt_with(ERR_BAD_HEX);
                    else
                    begin
                        hex_acc = {hex_acc[11:0], d[3:0]};
                        if (digits_seen != 2'd3)
                        begin
                            digits_seen = digits_seen + 2'd1;
                            add_result(8'h00, 1'b0, 1'b0, ERR_NONE);
                        end
                        else
                        begin
                            digits_seen = '0;
                            if (scan_phase == P_HEX1)
                            begin
                                if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff)
                                begin
                                    high_unit  = hex_acc;
                                    scan_phase = P_WANT_BS;
                                    add_result(8'h00, 1'b0, 1'b0, ERR_NONE);
                                end
                                else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff)
                                    halt_with(ERR_LONE_LOW);
                                else
                                begin
                                    scan_phase = P_BODY;
                                    add_utf8(int'(hex_acc));
                                end
                            end
                            else if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff)
                                halt_with(ERR_BAD_LOW);
                            else
                            begin
                                scan_phase = P_BODY;
                                add_utf8('h10000 + ((int'(high_unit) - 'hd800) << 10)
                                         + (int'(hex_acc) - 'hdc00));
                            end
                        end
                    end
                end
                P_WANT_BS:
                    if (w.in_byte != CH_BSLASH)
                        halt_with(ERR_NO_LOW_ESC);
                    else
                    begin
                        scan_phase = P_WANT_U;
                        add_result(8'h00, 1'b0, 1'b0, ERR_NONE);
                    end
                P_WANT_U:
                    if (w.in_byte != CH_U)
                        halt_with(ERR_NO_LOW_ESC);
                    else
                    begin
                        scan_phase  = P_HEX2;
                        digits_seen = '0;
                        hex_acc     = '0;
                        add_result(8'h00, 1'b0, 1'b0, ERR_NONE);
                    end
                default:
                    add_result(8'h00, 1'b0, 1'b0, ERR_NONE);
            endcase
        end
        word_results[word_results.size() - 1].last = 1'b1;
    endtask

    task automatic row_typed(logic kind, logic [7:0] b, logic [7:0] ob, logic has,
                             logic done, logic [3:0] err);
        row_t r;
        r.w.kind            = kind;
        r.w.in_byte         = b;
        r.typed             = 1'b1;
        r.want.out_byte     = ob;
        r.want.has_byte     = has;
        r.want.last         = 1'b1;
        r.want.string_done  = done;
        r.want.error_code   = err;
        script.push_back(r);
    endtask

    task automatic put_byte(logic [7:0] b);
        row_t r;
        r.w.kind    = KIND_DATA;
        r.w.in_byte = b;
        r.typed     = 1'b0;
        r.want      = '0;
        script.push_back(r);
    endtask

    task automatic put_end();
        row_t r;
        r.w.kind    = KIND_END;
        r.w.in_byte = 8'($urandom);
        r.typed     = 1'b0;
        r.want      = '0;
        script.push_back(r);
    endtask

    task automatic put_hex4(logic [15:0] v);
        for (int i = 3; i >= 0; i--)
            put_byte(hex_char(v[i * 4 +: 4], 1'($urandom)));
    endtask

    task automatic put_high_escape();
        put_byte(CH_BSLASH);
        put_byte(CH_U);
        put_hex4(16'($urandom_range('hd800, 'hdbff)));
    endtask

    task automatic put_segment();
        int sel;
        logic [7:0] b;
        sel = $urandom_range(0, 9);
        if (sel <= 4)
        begin
            do
                b = 8'($urandom_range(32, 255));
            while (b == CH_QUOTE || b == CH_BSLASH);
            put_byte(b);
        end
        else if (sel <= 6)
        begin
            do
                b = 8'($urandom);
            while (escape_code(b) < 0);
            put_byte(CH_BSLASH);
            put_byte(b);
        end
        else if (sel <= 8)
        begin
            put_byte(CH_BSLASH);
            put_byte(CH_U);
            case ($urandom_range(0, 3))
                0: put_hex4(16'($urandom_range(0, 'h7f)));
                1: put_hex4(16'($urandom_range('h80, 'h7ff)));
                2: put_hex4(16'($urandom_range('h800, 'hd7ff)));
                default: put_hex4(16'($urandom_range('he000, 'hffff)));
            endcase
        end
        else
        begin
            put_high_escape();
            put_byte(CH_BSLASH);
            put_byte(CH_U);
            put_hex4(16'($urandom_range('hdc00, 'hdfff)));
        end
    endtask

    task automatic put_fault(fault_e fault);
        logic [7:0] b;
        case (fault)
            FLT_CONTROL:
                put_byte(8'($urandom_range(0, 31)));
            FLT_BAD_ESCAPE:
            begin
                do
                    b = 8'($urandom);
                while (escape_code(b) >= 0 || b == CH_U);
                put_byte(CH_BSLASH);
                put_byte(b);
            end
            FLT_BAD_HEX:
            begin
                if ($urandom_range(0, 1) == 0)
                    put_high_escape();
                put_byte(CH_BSLASH);
                put_byte(CH_U);
                repeat ($urandom_range(0, 3))
                    put_byte(hex_char(4'($urandom), 1'($urandom)));
                do
                    b = 8'($urandom);
                while (digit_value(b) >= 0);
                put_byte(b);
            end
            FLT_NO_BSLASH:
            begin
                put_high_escape();
                do
                    b = 8'($urandom);
                while (b == CH_BSLASH);
                put_byte(b);
            end
            FLT_NO_U:
            begin
                put_high_escape();
                put_byte(CH_BSLASH);
                do
                    b = 8'($urandom);
                while (b == CH_U);
                put_byte(b);
            end
            FLT_BAD_LOW:
            begin
                put_high_escape();
                put_byte(CH_BSLASH);
                put_byte(CH_U);
                if ($urandom_range(0, 1) == 0)
                    put_hex4(16'($urandom_range(0, 'hdbff)));
                else
                    put_hex4(16'($urandom_range('he000, 'hffff)));
            end
            default:
            begin
                put_byte(CH_BSLASH);
                put_byte(CH_U);
                put_hex4(16'($urandom_range('hdc00, 'hdfff)));
            end
        endcase
    endtask

    task automatic make_string();
        int segs;
        int fault_at;
        fault_e fault;
        logic [7:0] b;
        segs     = $urandom_range(0, 10);
        fault_at = $urandom_range(0, segs);
        fault    = ($urandom_range(0, 9) < 3) ?
                   fault_e'($urandom_range(FLT_NO_QUOTE, FLT_EARLY_END)) : FLT_NONE;
        if (fault == FLT_NO_QUOTE)
        begin
            do
                b = 8'($urandom);
            while (b == CH_QUOTE);
            put_byte(b);
        end
        else
            put_byte(CH_QUOTE);
        for (int i = 0; i <= segs; i++)
        begin
            if (i == fault_at && fault >= FLT_CONTROL && fault <= FLT_LONE_LOW)
            begin
                put_fault(fault);
                break;
            end
            if (i < segs)
                put_segment();
        end
        if (fault != FLT_EARLY_END)
        begin
            if (fault == FLT_NONE || fault == FLT_NO_QUOTE)
                put_byte(CH_QUOTE);
            repeat ($urandom_range(0, 2))
                put_byte(8'($urandom));
        end
        put_end();
    endtask

    task automatic send_row(row_t r);
        @(negedge clk);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        item       <= r.w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        burst_left--;
        sent_words++;
        unescape_word(r.w);
        if (r.typed)
            expected_results.push_back(r.want);
        else
            foreach (word_results[i])
                expected_results.push_back(word_results[i]);
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end
        else
            mode_left--;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 2) == 0);
            default:
                if (stall_hold == 0)
                begin
                    result_stall <= ~result_stall;
                    stall_hold   = $urandom_range(1, 6);
                end
                else
                    stall_hold--;
        endcase
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word, got %p", $time, result);
                fails++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("out_byte", want.out_byte, result.out_byte);
                compare_field("has_byte", want.has_byte, result.has_byte);
                compare_field("last", want.last, result.last);
                compare_field("string_done", want.string_done, result.string_done);
                compare_field("error_code", want.error_code, result.error_code);
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;

        row_typed(KIND_DATA, "x", 8'h00, 1'b0, 1'b0, ERR_NO_QUOTE);
        row_typed(KIND_END, 8'hff, 8'h00, 1'b0, 1'b0, ERR_NONE);
        row_typed(KIND_END, 8'h00, 8'h00, 1'b0, 1'b0, ERR_UNTERMINATED);
        put_byte(CH_QUOTE);
        row_typed(KIND_DATA, 8'hff, 8'hff, 1'b1, 1'b0, ERR_NONE);
        put_byte(CH_BSLASH);
        put_byte(CH_U);
        put_byte("D");
        put_byte("B");
        put_byte("f");
        put_byte("F");
        put_byte(CH_BSLASH);
        put_byte(CH_U);
        put_byte("D");
        put_byte("F");
        put_byte("F");
        put_byte("F");
        put_byte(CH_BSLASH);
        row_typed(KIND_DATA, 8'h01, 8'h00, 1'b0, 1'b0, ERR_BAD_ESCAPE);
        row_typed(KIND_END, 8'h00, 8'h00, 1'b0, 1'b0, ERR_NONE);
        put_byte(CH_QUOTE);
        put_byte(CH_BSLASH);
        put_byte(CH_U);
        repeat (4)
            put_byte("0");
        row_typed(KIND_DATA, CH_QUOTE, 8'h00, 1'b0, 1'b1, ERR_NONE);
        row_typed(KIND_END, 8'h00, 8'h00, 1'b0, 1'b0, ERR_NONE);
        while (script.size() != 0)
            send_row(script.pop_front());

        while (sent_words < RANDOM_WORDS)
        begin
            make_string();
            while (script.size() != 0)
                send_row(script.pop_front());
        end
        @(negedge clk);
        item_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
